>>> rtl/core/midi_clock_tempo_meter_macros.svh
// Assertion macros shared by the tempo meter RTL.
`ifndef MIDI_CLOCK_TEMPO_METER_MACROS_SVH
`define MIDI_CLOCK_TEMPO_METER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MCTM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define MCTM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mctm_pkg.sv
package mctm_pkg;

	localparam int SRC_W      = 3;
	localparam int TS_W       = 32;
	localparam int TEMPO_W    = 24;
	localparam int MASK_W     = 8;
	localparam int COUNT_W    = 4;
	localparam int SCAN_IDX_W = 4;
	localparam int SCAN_CNT_W = 5;
	localparam int SCALE_W    = 30;

	localparam logic [SCALE_W-1:0] TEMPO_SCALE = 30'd640000000;
	localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 24'hFFFFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_META,
		ST_NEWEST,
		ST_SCAN,
		ST_TMETA,
		ST_TNEW,
		ST_TOLD,
		ST_START,
		ST_DIV,
		ST_LOAD
	} mctm_state_t;

	typedef struct packed {
		logic                  found;
		logic [SCAN_IDX_W-1:0] lowest;
		logic [MASK_W-1:0]     mask;
		logic [SCAN_CNT_W-1:0] count;
	} scan_t;

endpackage

>>> rtl/core/mctm_if.sv
interface mctm_pulse_if;
	logic                        valid;
	logic                        ready;
	logic [mctm_pkg::SRC_W-1:0]  source;
	logic [mctm_pkg::TS_W-1:0]   timestamp;

	modport src (output valid, source, timestamp, input ready);
	modport snk (input valid, source, timestamp, output ready);
endinterface

interface mctm_tempo_if;
	logic                         valid;
	logic                         ready;
	logic [mctm_pkg::TEMPO_W-1:0] tempo_q8;
	logic                         tempo_valid;
	logic [mctm_pkg::SRC_W-1:0]   tempo_source;
	logic                         was_duplicate;
	logic [mctm_pkg::MASK_W-1:0]  clocked_mask;
	logic [mctm_pkg::COUNT_W-1:0] clocked_count;

	modport src (output valid, tempo_q8, tempo_valid, tempo_source, was_duplicate,
		clocked_mask, clocked_count, input ready);
	modport snk (input valid, tempo_q8, tempo_valid, tempo_source, was_duplicate,
		clocked_mask, clocked_count, output ready);
endinterface

>>> rtl/core/mctm_div.sv
module mctm_div #(
	parameter int DW = 34
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DW-1:0]                 dividend,
	input  logic [mctm_pkg::TS_W-1:0]     divisor,
	output logic                          busy,
	output logic [DW-1:0]                 quotient
);

	localparam int CW = $clog2(DW + 1);

	logic                      busy_q;
	logic [CW-1:0]             cnt_q;
	logic [mctm_pkg::TS_W-1:0] rem_q;
	logic [mctm_pkg::TS_W-1:0] dsr_q;
	logic [DW-1:0]             dvd_q;
	logic [mctm_pkg::TS_W:0]   trial;
	logic                      fits;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? mctm_pkg::TS_W'(trial - {1'b0, dsr_q})
				: mctm_pkg::TS_W'(trial);
			dvd_q <= {dvd_q[DW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule

>>> rtl/core/mctm_scan.sv
module mctm_scan #(
	parameter int SOURCES = 8
) (
	input  logic [SOURCES-1:0]   clocked,
	output mctm_pkg::scan_t      scan
);

	always_comb begin
		logic                            found;
		logic [mctm_pkg::SCAN_IDX_W-1:0] lowest;
		logic [mctm_pkg::MASK_W-1:0]     mask;
		logic [mctm_pkg::SCAN_CNT_W-1:0] count;
		found  = 1'b0;
		lowest = '0;
		mask   = '0;
		count  = '0;
		for (int i = SOURCES - 1; i >= 0; i--) begin
			if (clocked[i]) begin
				found  = 1'b1;
				lowest = mctm_pkg::SCAN_IDX_W'(i);
			end
		end
		for (int i = 0; i < mctm_pkg::MASK_W; i++) begin
			if (i < SOURCES) begin
				mask[i] = clocked[i];
			end
		end
		for (int i = 0; i < SOURCES; i++) begin
			count = count + mctm_pkg::SCAN_CNT_W'(clocked[i]);
		end
		scan.found  = found;
		scan.lowest = lowest;
		scan.mask   = mask;
		scan.count  = count;
	end

endmodule

>>> rtl/core/midi_clock_tempo_meter.sv
// Channel   Role    Payload
// pulse     sink    source, timestamp
// tempo     source  tempo_q8, tempo_valid, tempo_source, was_duplicate,
//                   clocked_mask, clocked_count
//
// One item is taken at a time. An item passes through the states META, NEWEST, SCAN, TMETA,
// TNEW, TOLD, START, DIV and LOAD, and spends DIV in the bit-serial divider, which produces
// one quotient bit per cycle. An item with no valid tempo goes from TMETA straight to LOAD,
// and one with a zero span from TOLD straight to LOAD. Reset clears all control state and needs
// no clearing pass. A waiting result sits in the output register while the next item is
// taken; the block stalls only when a second result is ready before the first has left.
module midi_clock_tempo_meter #(
	parameter int SOURCES = 8,
	parameter int WINDOW  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	mctm_pulse_if.snk    pulse,
	mctm_tempo_if.src    tempo
);

`include "midi_clock_tempo_meter_macros.svh"

	localparam int SIW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int SW  = $clog2(WINDOW);
	localparam int NW  = $clog2(WINDOW + 1);
	localparam int AW  = $clog2(SOURCES * WINDOW);
	localparam int DW  = mctm_pkg::SCALE_W + SW;

	typedef struct packed {
		logic [NW-1:0] fill;
		logic [SW-1:0] slot;
	} meta_t;

	function automatic logic [SW-1:0] ring_prev(input logic [SW-1:0] slot);
		return (slot == '0) ? SW'(WINDOW - 1) : slot - 1'b1;
	endfunction

	function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] slot);
		return (slot == SW'(WINDOW - 1)) ? '0 : slot + 1'b1;
	endfunction

	function automatic logic [SW-1:0] ring_back(input logic [SW-1:0] slot,
		input logic [NW-1:0] n);
		logic [SW:0] a;
		logic [SW:0] b;
		a = (SW + 1)'(slot);
		b = (SW + 1)'(n);
		return (a >= b) ? SW'(a - b) : SW'(a + (SW + 1)'(WINDOW) - b);
	endfunction

	function automatic logic [AW-1:0] stamp_addr(input logic [SIW-1:0] idx,
		input logic [SW-1:0] slot);
		return AW'(AW'(idx) * AW'(WINDOW) + AW'(slot));
	endfunction

	mctm_pkg::mctm_state_t state_q, state_d;

	logic [31:0]                   stamp_mem [SOURCES * WINDOW];
	meta_t                         meta_mem  [SOURCES];

	logic [SOURCES-1:0]            clocked_q;
	logic [mctm_pkg::TS_W-1:0]     stamp_rdata_q;
	meta_t                         meta_rdata_q;
	logic                          meta_hit_q;
	logic [NW-1:0]                 fill_v;
	logic [SW-1:0]                 slot_v;

	logic                          ok_q;
	logic [SIW-1:0]                idx_q;
	logic [mctm_pkg::TS_W-1:0]     ts_q;
	logic [NW-1:0]                 fill_q;
	logic [SW-1:0]                 slot_q;
	logic                          dup_q;
	logic                          found_q;
	logic [SIW-1:0]                tidx_q;
	logic [mctm_pkg::MASK_W-1:0]   mask_q;
	logic [mctm_pkg::COUNT_W-1:0]  count_q;
	logic [mctm_pkg::TS_W-1:0]     newest_q;
	logic [mctm_pkg::TS_W-1:0]     span_q;
	logic [DW-1:0]                 dvd_q;
	logic [mctm_pkg::TEMPO_W-1:0]  res_tempo_q;
	logic                          res_valid_q;

	logic                          out_valid_q;
	logic [mctm_pkg::TEMPO_W-1:0]  out_tempo_q;
	logic                          out_tvalid_q;
	logic [mctm_pkg::SRC_W-1:0]    out_tsrc_q;
	logic                          out_dup_q;
	logic [mctm_pkg::MASK_W-1:0]   out_mask_q;
	logic [mctm_pkg::COUNT_W-1:0]  out_count_q;

	logic                          accept;
	logic                          load;
	logic                          dup_now;
	logic                          update;
	logic [SIW-1:0]                meta_raddr;
	logic [AW-1:0]                 stamp_raddr;
	logic [mctm_pkg::TS_W-1:0]     span_now;
	logic                          div_start;
	logic                          div_busy;
	logic [DW-1:0]                 div_quot;
	mctm_pkg::scan_t               scan;

	mctm_scan #(
		.SOURCES (SOURCES)
	) u_scan (
		.clocked (clocked_q),
		.scan    (scan)
	);

	mctm_div #(
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_q),
		.divisor  (span_q),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	assign fill_v   = meta_hit_q ? meta_rdata_q.fill : '0;
	assign slot_v   = meta_hit_q ? meta_rdata_q.slot : '0;
	assign dup_now  = ok_q && (fill_q != '0) && (stamp_rdata_q == ts_q);
	assign update   = ok_q && !dup_now;
	assign span_now = newest_q - stamp_rdata_q;
	assign accept   = pulse.valid && pulse.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mctm_pkg::ST_IDLE: begin
				if (pulse.valid) begin
					state_d = mctm_pkg::ST_META;
				end
			end
			mctm_pkg::ST_META:   state_d = mctm_pkg::ST_NEWEST;
			mctm_pkg::ST_NEWEST: state_d = mctm_pkg::ST_SCAN;
			mctm_pkg::ST_SCAN:   state_d = mctm_pkg::ST_TMETA;
			mctm_pkg::ST_TMETA: begin
				if (found_q && fill_v >= NW'(2)) begin
					state_d = mctm_pkg::ST_TNEW;
				end else begin
					state_d = mctm_pkg::ST_LOAD;
				end
			end
			mctm_pkg::ST_TNEW:   state_d = mctm_pkg::ST_TOLD;
			mctm_pkg::ST_TOLD: begin
				if (span_now == '0) begin
					state_d = mctm_pkg::ST_LOAD;
				end else begin
					state_d = mctm_pkg::ST_START;
				end
			end
			mctm_pkg::ST_START:  state_d = mctm_pkg::ST_DIV;
			mctm_pkg::ST_DIV: begin
				if (!div_busy) begin
					state_d = mctm_pkg::ST_LOAD;
				end
			end
			mctm_pkg::ST_LOAD: begin
				if (!out_valid_q || tempo.ready) begin
					state_d = mctm_pkg::ST_IDLE;
				end
			end
			default: state_d = mctm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pulse.ready = 1'b0;
		meta_raddr  = '0;
		stamp_raddr = '0;
		div_start   = 1'b0;
		load        = 1'b0;
		case (state_q)
			mctm_pkg::ST_IDLE: begin
				pulse.ready = 1'b1;
				if (32'(pulse.source) < SOURCES) begin
					meta_raddr = SIW'(pulse.source);
				end
			end
			mctm_pkg::ST_META:  stamp_raddr = stamp_addr(idx_q, ring_prev(slot_v));
			mctm_pkg::ST_SCAN:  meta_raddr = SIW'(scan.lowest);
			mctm_pkg::ST_TMETA: stamp_raddr = stamp_addr(tidx_q, ring_prev(slot_v));
			mctm_pkg::ST_TNEW:  stamp_raddr = stamp_addr(tidx_q, ring_back(slot_q, fill_q));
			mctm_pkg::ST_START: div_start = 1'b1;
			mctm_pkg::ST_LOAD:  load = !out_valid_q || tempo.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mctm_pkg::ST_IDLE;
			clocked_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mctm_pkg::ST_NEWEST && update) begin
				clocked_q[idx_q] <= 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (tempo.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mctm_pkg::ST_NEWEST && update) begin
			meta_mem[idx_q] <= '{fill: (fill_q == NW'(WINDOW)) ? fill_q : fill_q + 1'b1,
				slot: ring_next(slot_q)};
		end
		meta_rdata_q <= meta_mem[meta_raddr];
		meta_hit_q   <= clocked_q[meta_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == mctm_pkg::ST_NEWEST && update) begin
			stamp_mem[stamp_addr(idx_q, slot_q)] <= ts_q;
		end
		stamp_rdata_q <= stamp_mem[stamp_raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mctm_pkg::ST_IDLE: begin
				if (accept) begin
					ok_q  <= 32'(pulse.source) < SOURCES;
					idx_q <= (32'(pulse.source) < SOURCES) ? SIW'(pulse.source) : '0;
					ts_q  <= pulse.timestamp;
				end
			end
			mctm_pkg::ST_META: begin
				fill_q <= fill_v;
				slot_q <= slot_v;
			end
			mctm_pkg::ST_NEWEST: dup_q <= dup_now;
			mctm_pkg::ST_SCAN: begin
				found_q <= scan.found;
				tidx_q  <= SIW'(scan.lowest);
				mask_q  <= scan.mask;
				count_q <= mctm_pkg::COUNT_W'(scan.count);
			end
			mctm_pkg::ST_TMETA: begin
				fill_q      <= fill_v;
				slot_q      <= slot_v;
				res_tempo_q <= '0;
				res_valid_q <= 1'b0;
			end
			mctm_pkg::ST_TNEW: newest_q <= stamp_rdata_q;
			mctm_pkg::ST_TOLD: begin
				span_q      <= span_now;
				dvd_q       <= DW'(mctm_pkg::TEMPO_SCALE) * DW'(fill_q - 1'b1);
				res_tempo_q <= mctm_pkg::TEMPO_MAX;
				res_valid_q <= 1'b1;
			end
			mctm_pkg::ST_DIV: begin
				if (!div_busy) begin
					res_tempo_q <= (div_quot[DW-1:mctm_pkg::TEMPO_W] != '0)
						? mctm_pkg::TEMPO_MAX : div_quot[mctm_pkg::TEMPO_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_tempo_q  <= res_tempo_q;
			out_tvalid_q <= res_valid_q;
			out_tsrc_q   <= mctm_pkg::SRC_W'(tidx_q);
			out_dup_q    <= dup_q;
			out_mask_q   <= mask_q;
			out_count_q  <= count_q;
		end
	end

	assign tempo.valid         = out_valid_q;
	assign tempo.tempo_q8      = out_tempo_q;
	assign tempo.tempo_valid   = out_tvalid_q;
	assign tempo.tempo_source  = out_tsrc_q;
	assign tempo.was_duplicate = out_dup_q;
	assign tempo.clocked_mask  = out_mask_q;
	assign tempo.clocked_count = out_count_q;

	`MCTM_ASSERT_NXT(a_div_runs, div_start, div_busy, "divider did not start")
	`MCTM_ASSERT_IMP(a_load_free, load, !out_valid_q || tempo.ready, "result overwritten")
	`MCTM_ASSERT_IMP(a_valid_clocked, tempo.valid && tempo.tempo_valid, clocked_q != '0, "no clock")

endmodule
